/* rtl/text_stream_line_numberer_escaper_assert.svh */
// Assertion macros for the text stream line numberer and escaper.
`ifndef TEXT_STREAM_LINE_NUMBERER_ESCAPER_ASSERT_SVH
`define TEXT_STREAM_LINE_NUMBERER_ESCAPER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define TSLE_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("tsle assertion failed");

// Next-cycle implication.
`define TSLE_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("tsle assertion failed");

`else

`define TSLE_ASSERT_IMP(label, clk_s, rst_s, ante, cons)
`define TSLE_ASSERT_NXT(label, clk_s, rst_s, ante, cons)

`endif

`endif

/* rtl/tsle_pkg.sv */
// Shared types, constants and helper functions of the line numberer / escaper.
package tsle_pkg;

  localparam int NUMBER_DIGITS = 6;
  localparam int DIGITS_W      = 4 * NUMBER_DIGITS;
  localparam int DIDX_W        = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_ALL      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_NONBLANK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_ENDS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINT   = 3'd5;

  // character codes
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CH_CTRL_END = 8'd32;
  localparam logic [7:0] META_LO   = 8'd128;
  localparam logic [7:0] META_HI   = 8'd160;
  localparam logic [7:0] CARET_OFS = 8'd64;

  // escape prefix kinds
  localparam logic [1:0] PRE_NONE  = 2'd0;
  localparam logic [1:0] PRE_CARET = 2'd1;
  localparam logic [1:0] PRE_META  = 2'd2;

  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze;
    logic show_ends;
    logic show_tabs;
    logic show_nonprint;
  } cfg_t;

  // one classified input byte, as queued for the back end
  typedef struct packed {
    logic                num;
    logic [DIGITS_W-1:0] digits;
    logic                dol;
    logic [1:0]          pre;
    logic [7:0]          chr;
  } cmd_t;

  // BCD increment that sticks at all nines
  function automatic logic [DIGITS_W-1:0] bcd_inc(input logic [DIGITS_W-1:0] v);
    logic [DIGITS_W-1:0] res;
    logic                carry;
    logic                all9;
    int                  i;
    res   = v;
    carry = 1'b1;
    all9  = 1'b1;
    for (i = 0; i < NUMBER_DIGITS; i++) begin
      if (v[4*i +: 4] != 4'd9) all9 = 1'b0;
    end
    for (i = 0; i < NUMBER_DIGITS; i++) begin
      if (carry) begin
        if (v[4*i +: 4] >= 4'd9) begin
          res[4*i +: 4] = 4'd0;
        end else begin
          res[4*i +: 4] = v[4*i +: 4] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    return all9 ? v : res;
  endfunction

  function automatic logic bcd_ok(input logic [DIGITS_W-1:0] v);
    logic ok;
    int   i;
    ok = 1'b1;
    for (i = 0; i < NUMBER_DIGITS; i++) begin
      if (v[4*i +: 4] > 4'd9) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

/* rtl/tsle_in_if.sv */
// Input byte channel.
interface tsle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_file;

  modport source (output valid, in_byte, start_of_file, input ready);
  modport sink   (input valid, in_byte, start_of_file, output ready);
endinterface

/* rtl/tsle_out_if.sv */
// Output byte channel.
interface tsle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

/* rtl/tsle_cfg_if.sv */
// Configuration write channel.
interface tsle_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tsle_pkg::CFG_IDX_W-1:0] index;
  logic                           data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/tsle_front.sv */
// Front end: stream state, squeezing, numbering decision and escape classification.
module tsle_front (
  input  logic              clk,
  input  logic              rst,
  input  tsle_pkg::cfg_t    cfg_regs,
  tsle_in_if.sink           stream_in,
  input  logic              fifo_full,
  output logic              push,
  output tsle_pkg::cmd_t    push_entry
);

  logic                          prev_nl;
  logic [1:0]                    blank_run;
  logic [tsle_pkg::DIGITS_W-1:0] digits;

  logic                          prev_nl_eff;
  logic [1:0]                    blank_eff;
  logic [tsle_pkg::DIGITS_W-1:0] digits_eff;
  logic [1:0]                    blank_next;
  logic                          is_nl;
  logic                          drop;
  logic                          num;
  logic                          accept;
  logic [7:0]                    c;

  assign stream_in.ready = !fifo_full;
  assign accept          = stream_in.valid && stream_in.ready;
  assign c               = stream_in.in_byte;
  assign is_nl           = (c == tsle_pkg::CH_NL);

  // start of file restarts the stream state before this byte is handled
  assign prev_nl_eff = stream_in.start_of_file ? 1'b1 : prev_nl;
  assign blank_eff   = stream_in.start_of_file ? 2'd0 : blank_run;
  assign digits_eff  = stream_in.start_of_file ? tsle_pkg::DIGITS_W'(1) : digits;

  always_comb begin
    blank_next = blank_eff;
    if (cfg_regs.squeeze) begin
      if (is_nl && prev_nl_eff) begin
        if (blank_eff < 2'd2) blank_next = blank_eff + 2'd1;
      end else begin
        blank_next = 2'd0;
      end
    end
  end

  assign drop = (blank_next >= 2'd2);
  assign num  = prev_nl_eff &&
                (cfg_regs.number_nonblank ? !is_nl : cfg_regs.number_all);
  assign push = accept && !drop;

  always_comb begin
    push_entry.num    = num;
    push_entry.digits = digits_eff;
    push_entry.dol    = cfg_regs.show_ends && is_nl;
    push_entry.pre    = tsle_pkg::PRE_NONE;
    push_entry.chr    = c;
    priority if (cfg_regs.show_tabs && c == tsle_pkg::CH_TAB) begin
      push_entry.pre = tsle_pkg::PRE_CARET;
      push_entry.chr = tsle_pkg::CH_I;
    end else if (cfg_regs.show_nonprint && !is_nl && c != tsle_pkg::CH_TAB) begin
      priority if (c >= tsle_pkg::META_LO && c < tsle_pkg::META_HI) begin
        push_entry.pre = tsle_pkg::PRE_META;
        push_entry.chr = c - tsle_pkg::CARET_OFS;
      end else if (c < tsle_pkg::CH_CTRL_END) begin
        push_entry.pre = tsle_pkg::PRE_CARET;
        push_entry.chr = c + tsle_pkg::CARET_OFS;
      end else if (c == tsle_pkg::CH_DEL) begin
        push_entry.pre = tsle_pkg::PRE_CARET;
        push_entry.chr = tsle_pkg::CH_QMARK;
      end else begin
        push_entry.pre = tsle_pkg::PRE_NONE;
      end
    end else begin
      push_entry.pre = tsle_pkg::PRE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_nl   <= 1'b1;
      blank_run <= 2'd0;
      digits    <= tsle_pkg::DIGITS_W'(1);
    end else if (accept) begin
      blank_run <= blank_next;
      prev_nl   <= drop ? prev_nl_eff : is_nl;
      digits    <= (num && !drop) ? tsle_pkg::bcd_inc(digits_eff) : digits_eff;
    end
  end

endmodule

/* rtl/tsle_fifo.sv */
// Short command queue between front and back end.
module tsle_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tsle_pkg::cmd_t wdata,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output tsle_pkg::cmd_t head
);

  tsle_pkg::cmd_t                  mem [tsle_pkg::FIFO_DEPTH];
  logic [tsle_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [tsle_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [tsle_pkg::FIFO_CNT_W-1:0] count;

  assign full       = (count == tsle_pkg::FIFO_CNT_W'(tsle_pkg::FIFO_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == tsle_pkg::FIFO_PTR_W'(tsle_pkg::FIFO_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == tsle_pkg::FIFO_PTR_W'(tsle_pkg::FIFO_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/tsle_back.sv */
// Back end: walks one queued command byte by byte into the output register.
module tsle_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  tsle_pkg::cmd_t head,
  output logic           pop,
  tsle_out_if.source     stream_out
);

  localparam logic [2:0] PH_NUM   = 3'd0;
  localparam logic [2:0] PH_TAB   = 3'd1;
  localparam logic [2:0] PH_DOL   = 3'd2;
  localparam logic [2:0] PH_M     = 3'd3;
  localparam logic [2:0] PH_DASH  = 3'd4;
  localparam logic [2:0] PH_CARET = 3'd5;
  localparam logic [2:0] PH_CHR   = 3'd6;

  logic                          active;
  logic [2:0]                    phase;
  logic [tsle_pkg::DIDX_W-1:0]   idx;
  logic                          out_valid;
  logic [7:0]                    out_byte;
  logic                          out_last;

  logic [2:0]                    after_dol;
  logic [2:0]                    first_ph;
  logic [2:0]                    eff_ph;
  logic [2:0]                    next_ph;
  logic [tsle_pkg::DIDX_W-1:0]   eff_idx;
  logic [3:0]                    digit;
  logic [tsle_pkg::NUMBER_DIGITS-1:0] blank;
  logic [7:0]                    sel_byte;
  logic                          is_last;
  logic                          load;

  assign stream_out.valid       = out_valid;
  assign stream_out.out_byte    = out_byte;
  assign stream_out.last_of_run = out_last;

  always_comb begin
    unique case (head.pre)
      tsle_pkg::PRE_META:  after_dol = PH_M;
      tsle_pkg::PRE_CARET: after_dol = PH_CARET;
      default:             after_dol = PH_CHR;
    endcase
  end

  assign first_ph = head.num ? PH_NUM : (head.dol ? PH_DOL : after_dol);
  assign eff_ph   = active ? phase : first_ph;
  assign eff_idx  = active ? idx : tsle_pkg::DIDX_W'(tsle_pkg::NUMBER_DIGITS - 1);
  assign digit    = head.digits[eff_idx*4 +: 4];

  // leading zeros print as spaces; the units digit always prints
  always_comb begin
    for (int i = 0; i < tsle_pkg::NUMBER_DIGITS; i++) begin
      blank[i] = (i != 0) && ((head.digits >> (4*i)) == '0);
    end
  end

  always_comb begin
    next_ph  = PH_CHR;
    sel_byte = head.chr;
    unique case (eff_ph)
      PH_NUM: begin
        sel_byte = blank[eff_idx] ? tsle_pkg::CH_SPACE : (tsle_pkg::CH_ZERO + {4'd0, digit});
        next_ph  = (eff_idx == '0) ? PH_TAB : PH_NUM;
      end
      PH_TAB: begin
        sel_byte = tsle_pkg::CH_TAB;
        next_ph  = head.dol ? PH_DOL : after_dol;
      end
      PH_DOL: begin
        sel_byte = tsle_pkg::CH_DOLLAR;
        next_ph  = after_dol;
      end
      PH_M: begin
        sel_byte = tsle_pkg::CH_M;
        next_ph  = PH_DASH;
      end
      PH_DASH: begin
        sel_byte = tsle_pkg::CH_DASH;
        next_ph  = PH_CARET;
      end
      PH_CARET: begin
        sel_byte = tsle_pkg::CH_CARET;
        next_ph  = PH_CHR;
      end
      default: begin
        sel_byte = head.chr;
        next_ph  = PH_CHR;
      end
    endcase
  end

  assign is_last = (eff_ph == PH_CHR);
  assign load    = head_valid && (!out_valid || stream_out.ready);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= sel_byte;
      out_last <= is_last;
      idx      <= (eff_ph == PH_NUM) ? eff_idx - 1'b1 : eff_idx;
      phase    <= next_ph;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      active    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        active    <= !is_last;
      end else if (stream_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/text_stream_line_numberer_escaper.sv */
// Top level of the text stream line numberer and escaper.
//
//  channel     | dir | handshake     | payload
//  ------------+-----+---------------+--------------------------------
//  stream_in   | in  | valid / ready | in_byte[7:0], start_of_file
//  stream_out  | out | valid / ready | out_byte[7:0], last_of_run
//  cfg         | in  | valid / ready | index[2:0], data (ready always 1)
//
// One output byte per cycle from a single output register while commands
// are queued and stream_out is ready. An input byte yields 1 ..
// NUMBER_DIGITS+5 bytes; squeezed bytes are not queued. The two-entry
// command queue lets the front end take bytes while the back end emits a
// number prefix. Synchronous reset clears stream state, registers, queue.
`include "text_stream_line_numberer_escaper_assert.svh"

module text_stream_line_numberer_escaper (
  input  logic        clk,
  input  logic        rst,
  tsle_in_if.sink     stream_in,
  tsle_out_if.source  stream_out,
  tsle_cfg_if.sink    cfg
);

  tsle_pkg::cfg_t cfg_regs;
  logic           push;
  tsle_pkg::cmd_t push_entry;
  logic           pop;
  logic           fifo_full;
  logic           head_valid;
  tsle_pkg::cmd_t head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        tsle_pkg::REG_NUMBER_ALL:      cfg_regs.number_all      <= cfg.data;
        tsle_pkg::REG_NUMBER_NONBLANK: cfg_regs.number_nonblank <= cfg.data;
        tsle_pkg::REG_SQUEEZE:         cfg_regs.squeeze         <= cfg.data;
        tsle_pkg::REG_SHOW_ENDS:       cfg_regs.show_ends       <= cfg.data;
        tsle_pkg::REG_SHOW_TABS:       cfg_regs.show_tabs       <= cfg.data;
        tsle_pkg::REG_SHOW_NONPRINT:   cfg_regs.show_nonprint   <= cfg.data;
        default:                       cfg_regs                 <= cfg_regs;
      endcase
    end
  end

  tsle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_regs   (cfg_regs),
    .stream_in  (stream_in),
    .fifo_full  (fifo_full),
    .push       (push),
    .push_entry (push_entry)
  );

  tsle_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wdata      (push_entry),
    .pop        (pop),
    .full       (fifo_full),
    .head_valid (head_valid),
    .head       (head)
  );

  tsle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .stream_out (stream_out)
  );

  `TSLE_ASSERT_IMP(a_push_not_full, clk, rst, push, !fifo_full)
  `TSLE_ASSERT_NXT(a_pop_marks_last, clk, rst, pop, stream_out.valid && stream_out.last_of_run)
  `TSLE_ASSERT_IMP(a_digits_bcd, clk, rst, push, tsle_pkg::bcd_ok(push_entry.digits))

endmodule
